// ===== rtl/gcd_pkg.sv =====
package gcd_pkg;

  // CORDIC datapath
  localparam int STEPS = 30;
  localparam int CW    = 34;
  localparam int FRAC  = 30;

  localparam logic signed [CW-1:0] ATAN_TAB [STEPS] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149,
    34'sd1048575, 34'sd524287, 34'sd262143, 34'sd131071, 34'sd65535,
    34'sd32767, 34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
    34'sd1023, 34'sd511, 34'sd255, 34'sd127, 34'sd63,
    34'sd31, 34'sd15, 34'sd8, 34'sd4, 34'sd2
  };

  // Restoring square root of (v << FRAC)
  localparam int SQ_STEPS = 31;
  localparam int SQ_W     = 62;
  localparam int ROOT_W   = 31;

  // Angles in microdegrees
  localparam int MDEG_W = 28;
  localparam logic [MDEG_W-1:0] MDEG90  = 28'd90000000;
  localparam logic [MDEG_W-1:0] MDEG180 = 28'd180000000;
  localparam logic signed [31:0] WRAP_HALF = 32'sd180000000;
  localparam logic signed [31:0] WRAP_FULL = 32'sd360000000;

  // Microdegrees to radians, split for two narrow multipliers
  localparam logic [33:0] KRAD    = 34'd10061138136;
  localparam int          KSPLIT  = 17;
  localparam logic [16:0] KRAD_LO = KRAD[16:0];
  localparam logic [16:0] KRAD_HI = KRAD[33:17];
  localparam int          PP_W    = MDEG_W + KSPLIT;
  localparam int          PROD_W  = 62;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [ROOT_W-1:0]    ONE_Q30     = 31'd1073741824;
  localparam logic [23:0]          EARTH_2R    = 24'd12742000;
  localparam logic [24:0]          DIST_MAX    = 25'd20015087;

endpackage

// ===== rtl/gcd_cordic.sv =====
module gcd_cordic import gcd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 vec_i,  // 1: vectoring toward y = 0, 0: rotation by z
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [CW-1:0] z_o
);

  logic signed [CW-1:0] x_q [STEPS];
  logic signed [CW-1:0] y_q [STEPS];
  logic signed [CW-1:0] z_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic signed [CW-1:0] xs, ys, zs, dx, dy;
    logic                 pos;

    if (i == 0) begin : g_first
      assign xs = x_i;
      assign ys = y_i;
      assign zs = z_i;
    end else begin : g_next
      assign xs = x_q[i-1];
      assign ys = y_q[i-1];
      assign zs = z_q[i-1];
    end

    assign dx  = ys >>> i;
    assign dy  = xs >>> i;
    // vectoring: y above the axis rotates clockwise; rotation: follow sign of residue
    assign pos = vec_i ? (ys > 0) : !zs[CW-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (vec_i) begin
          if (pos) begin
            x_q[i] <= xs + dx;
            y_q[i] <= ys - dy;
            z_q[i] <= zs + ATAN_TAB[i];
          end else begin
            x_q[i] <= xs - dx;
            y_q[i] <= ys + dy;
            z_q[i] <= zs - ATAN_TAB[i];
          end
        end else begin
          if (pos) begin
            x_q[i] <= xs - dx;
            y_q[i] <= ys + dy;
            z_q[i] <= zs - ATAN_TAB[i];
          end else begin
            x_q[i] <= xs + dx;
            y_q[i] <= ys - dy;
            z_q[i] <= zs + ATAN_TAB[i];
          end
        end
      end
    end
  end

  assign x_o = x_q[STEPS-1];
  assign y_o = y_q[STEPS-1];
  assign z_o = z_q[STEPS-1];

endmodule

// ===== rtl/gcd_isqrt.sv =====
module gcd_isqrt import gcd_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [ROOT_W-1:0] v_i,
  output logic [ROOT_W-1:0] r_o
);

  logic [SQ_W-1:0] n_q [SQ_STEPS];
  logic [SQ_W-1:0] r_q [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1) - 2 * i);
    logic [SQ_W-1:0] ns, rs, trial;

    if (i == 0) begin : g_first
      assign ns = SQ_W'(v_i) << FRAC;
      assign rs = '0;
    end else begin : g_next
      assign ns = n_q[i-1];
      assign rs = r_q[i-1];
    end

    assign trial = rs + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ns >= trial) begin
          n_q[i] <= ns - trial;
          r_q[i] <= (rs >> 1) + BIT;
        end else begin
          n_q[i] <= ns;
          r_q[i] <= rs >> 1;
        end
      end
    end
  end

  assign r_o = r_q[SQ_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/great_circle_distance_core.sv =====
// Great-circle distance between two positions by the haversine formula.
//
// Input stream: one transaction carries lat_a, lon_a, lat_b, lon_b in
// microdegrees (two's complement). Output stream: one transaction per input
// carrying distance_m, the distance in whole meters rounded to nearest and
// saturated at half the Earth's circumference (20015087 m).
//
// The datapath is a fixed pipeline: degree-to-radian conversion (3 stages),
// sine/cosine CORDIC (30), haversine products and clamp (3), square roots
// (31), atan2 CORDIC (30) and scaling (2). While the receiver does not stall,
// one transaction is taken every cycle, so sustained throughput is one item
// per clock.
//
// The whole pipeline advances together whenever the output register is empty
// or being read. When the receiver stalls with a result waiting, every stage
// holds and s_axis_tready drops; nothing is lost or repeated.
//
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers
// keep whatever they held and are ignored until new items arrive.
module great_circle_distance_core import gcd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,   // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata    // distance_m[24:0]
);

  typedef struct packed {
    logic vld;
    logic neg_a;   // cos of lat_a taken by reflection, negate it
    logic neg_b;
  } ctl_t;

  function automatic logic signed [31:0] wrap360(input logic signed [31:0] d);
    if (d >= WRAP_HALF) begin
      return d - WRAP_FULL;
    end else if (d < -WRAP_HALF) begin
      return d + WRAP_FULL;
    end
    return d;
  endfunction

  function automatic logic [MDEG_W-1:0] mag28(input logic signed [31:0] d);
    return MDEG_W'(d[31] ? -d : d);
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return 32'(p >>> FRAC);
  endfunction

  // Advance the whole pipeline when the output slot frees up
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------------
  // P0: unpack, difference, wrap, fold latitudes
  // ---------------------------------------------------------------------
  logic signed [27:0] in_lat_a, in_lat_b;
  logic signed [28:0] in_lon_a, in_lon_b;
  assign in_lat_a = s_axis_tdata[27:0];
  assign in_lon_a = s_axis_tdata[56:28];
  assign in_lat_b = s_axis_tdata[84:57];
  assign in_lon_b = s_axis_tdata[113:85];

  logic signed [31:0] dlat, dlon;
  logic [MDEG_W-1:0]  ma, mb;
  assign dlat = wrap360(32'(in_lat_b) - 32'(in_lat_a));
  assign dlon = wrap360(32'(in_lon_b) - 32'(in_lon_a));
  assign ma   = mag28(32'(in_lat_a));
  assign mb   = mag28(32'(in_lat_b));

  ctl_t              p0_ctl_q, p1_ctl_q, p2_ctl_q;
  logic [MDEG_W-1:0] p0_mag_q [4];   // cos lat_a, cos lat_b, dlat, dlon
  logic [1:0]        p0_sgn_q, p1_sgn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_ctl_q <= '0;
    end else if (en) begin
      p0_ctl_q.vld   <= s_axis_tvalid;
      p0_ctl_q.neg_a <= ma > MDEG90;
      p0_ctl_q.neg_b <= mb > MDEG90;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_mag_q[0] <= (ma > MDEG90) ? MDEG180 - ma : ma;
      p0_mag_q[1] <= (mb > MDEG90) ? MDEG180 - mb : mb;
      p0_mag_q[2] <= mag28(dlat);
      p0_mag_q[3] <= mag28(dlon);
      p0_sgn_q    <= {dlon[31], dlat[31]};
    end
  end

  // ---------------------------------------------------------------------
  // P1: partial products of magnitude times radian constant
  // ---------------------------------------------------------------------
  logic [PP_W-1:0] p1_hi_q [4];
  logic [PP_W-1:0] p1_lo_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_ctl_q <= '0;
      p2_ctl_q <= '0;
    end else if (en) begin
      p1_ctl_q <= p0_ctl_q;
      p2_ctl_q <= p1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p1_hi_q[k] <= PP_W'(p0_mag_q[k]) * PP_W'(KRAD_HI);
        p1_lo_q[k] <= PP_W'(p0_mag_q[k]) * PP_W'(KRAD_LO);
      end
      p1_sgn_q <= p0_sgn_q;
    end
  end

  // ---------------------------------------------------------------------
  // P2: sum, round, restore sign, double into the Q4.30 residue
  // Full angles (cosines) shift by 30, half angles by 31.
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] p2_z_q [4];

  always_ff @(posedge clk_i) begin
    logic [PROD_W-1:0] prod;
    logic [CW-1:0]     rad;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod = (PROD_W'(p1_hi_q[k]) << KSPLIT) + PROD_W'(p1_lo_q[k]);
        if (k < 2) begin
          rad = CW'((prod + (PROD_W'(1) << (FRAC - 1))) >> FRAC);
          p2_z_q[k] <= signed'(rad << 1);
        end else begin
          rad = CW'((prod + (PROD_W'(1) << FRAC)) >> (FRAC + 1));
          p2_z_q[k] <= p1_sgn_q[k-2] ? -signed'(rad << 1) : signed'(rad << 1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sine and cosine, four rotation CORDICs side by side
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] cos_a, cos_b, sin_lat, sin_lon;

  gcd_cordic u_cos_a (
    .clk_i (clk_i), .en_i (en), .vec_i (1'b0),
    .x_i (CORDIC_GAIN), .y_i ('0), .z_i (p2_z_q[0]),
    .x_o (cos_a), .y_o (), .z_o ()
  );

  gcd_cordic u_cos_b (
    .clk_i (clk_i), .en_i (en), .vec_i (1'b0),
    .x_i (CORDIC_GAIN), .y_i ('0), .z_i (p2_z_q[1]),
    .x_o (cos_b), .y_o (), .z_o ()
  );

  gcd_cordic u_sin_lat (
    .clk_i (clk_i), .en_i (en), .vec_i (1'b0),
    .x_i (CORDIC_GAIN), .y_i ('0), .z_i (p2_z_q[2]),
    .x_o (), .y_o (sin_lat), .z_o ()
  );

  gcd_cordic u_sin_lon (
    .clk_i (clk_i), .en_i (en), .vec_i (1'b0),
    .x_i (CORDIC_GAIN), .y_i ('0), .z_i (p2_z_q[3]),
    .x_o (), .y_o (sin_lon), .z_o ()
  );

  ctl_t cd_q [STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STEPS; k++) cd_q[k] <= '0;
    end else if (en) begin
      cd_q[0] <= p2_ctl_q;
      for (int k = 1; k < STEPS; k++) cd_q[k] <= cd_q[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // Q1..Q3: haversine term a = s_lat^2 + cos_a*cos_b*s_lon^2, clamp to [0,1]
  // ---------------------------------------------------------------------
  logic signed [31:0] ca, cb;
  assign ca = cd_q[STEPS-1].neg_a ? -32'(cos_a) : 32'(cos_a);
  assign cb = cd_q[STEPS-1].neg_b ? -32'(cos_b) : 32'(cos_b);

  logic               q1_vld_q, q2_vld_q, q3_vld_q;
  logic signed [31:0] q1_hlat_q, q1_hlon_q, q1_cc_q;
  logic signed [31:0] q2_hlat_q, q2_t_q;
  logic [ROOT_W-1:0]  a_q, b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_vld_q <= 1'b0;
      q2_vld_q <= 1'b0;
      q3_vld_q <= 1'b0;
    end else if (en) begin
      q1_vld_q <= cd_q[STEPS-1].vld;
      q2_vld_q <= q1_vld_q;
      q3_vld_q <= q2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [32:0] sum;
    if (en) begin
      q1_hlat_q <= qmul(32'(sin_lat), 32'(sin_lat));
      q1_hlon_q <= qmul(32'(sin_lon), 32'(sin_lon));
      q1_cc_q   <= qmul(ca, cb);
      q2_hlat_q <= q1_hlat_q;
      q2_t_q    <= qmul(q1_cc_q, q1_hlon_q);
      sum = 33'(q2_hlat_q) + 33'(q2_t_q);
      // Clamp to [0, 1] in Q1.30
      if (sum[32]) begin
        a_q <= '0;
        b_q <= ONE_Q30;
      end else if (sum > 33'(ONE_Q30)) begin
        a_q <= ONE_Q30;
        b_q <= '0;
      end else begin
        a_q <= ROOT_W'(sum);
        b_q <= ONE_Q30 - ROOT_W'(sum);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Square roots of a and 1 - a
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] root_a, root_b;

  gcd_isqrt u_sqrt_a (.clk_i (clk_i), .en_i (en), .v_i (a_q), .r_o (root_a));
  gcd_isqrt u_sqrt_b (.clk_i (clk_i), .en_i (en), .v_i (b_q), .r_o (root_b));

  logic sv_q [SQ_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ_STEPS; k++) sv_q[k] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= q3_vld_q;
      for (int k = 1; k < SQ_STEPS; k++) sv_q[k] <= sv_q[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // Central angle: vectoring CORDIC on (sqrt(1-a), sqrt(a))
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] ang;

  gcd_cordic u_atan2 (
    .clk_i (clk_i), .en_i (en), .vec_i (1'b1),
    .x_i (CW'(root_b)), .y_i (CW'(root_a)), .z_i ('0),
    .x_o (), .y_o (), .z_o (ang)
  );

  logic av_q [STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STEPS; k++) av_q[k] <= 1'b0;
    end else if (en) begin
      av_q[0] <= sv_q[SQ_STEPS-1];
      for (int k = 1; k < STEPS; k++) av_q[k] <= av_q[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // D1: scale by 2R; D2: round, saturate, hold for the receiver
  // ---------------------------------------------------------------------
  logic        d1_vld_q, out_vld_q;
  logic [54:0] d1_prod_q;
  logic [24:0] out_dist_q;
  logic [25:0] dist_rnd;

  assign dist_rnd = 26'((d1_prod_q + 55'd536870912) >> FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      d1_vld_q  <= av_q[STEPS-1];
      out_vld_q <= d1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Drop a negative residue to zero before scaling
      d1_prod_q  <= 55'(EARTH_2R) * (ang[CW-1] ? 55'd0 : 55'(ang[30:0]));
      out_dist_q <= (dist_rnd > 26'(DIST_MAX)) ? DIST_MAX : dist_rnd[24:0];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_dist_q};

`ifndef SYNTHESIS
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[24:0] <= DIST_MAX))
    else $error("distance above saturation limit");

  a_hav_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q3_vld_q |-> ((a_q <= ONE_Q30) && (32'(a_q) + 32'(b_q) == 32'(ONE_Q30))))
    else $error("haversine term out of range");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> p0_ctl_q.vld)
    else $error("accepted transaction not captured");
`endif

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam longint DEG180 = 180000000;
  localparam longint DEG90 = 90000000;
  localparam longint DEG360 = 360000000;
  localparam longint KRAD_L = 64'd10061138136;
  localparam longint GAIN_L = 652032874;
  localparam longint ONE_L = 1073741824;
  localparam longint DMAX_L = 20015087;

  typedef struct packed {
    logic signed [28:0] lon_b;
    logic signed [27:0] lat_b;
    logic signed [28:0] lon_a;
    logic signed [27:0] lat_a;
  } coord_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  int src_gap_pct = 0;
  int snk_stall_pct = 0;
  int err_cnt = 0;
  int idle_cycles = 0;

  great_circle_distance_core dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Bit-true haversine distance in 64-bit integer arithmetic.
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint deg_to_rad(longint u, int sh);
    longint unsigned mag, r;
    mag = (u < 0) ? -u : u;
    r = (mag * KRAD_L + (64'd1 << (sh - 1))) >> sh;
    return (u < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return asr(a * b + (ONE_L >>> 1), 30);
  endfunction

  function automatic void rotate(longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = GAIN_L;
    y = 0;
    for (int i = 0; i < gcd_pkg::STEPS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(gcd_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(gcd_pkg::ATAN_TAB[i]);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint root_q30(longint v);
    longint unsigned n, r, b;
    n = longint'(v) << 30;
    r = 0;
    b = 64'd1 << 60;
    for (int i = 0; i < 31; i++) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < gcd_pkg::STEPS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(gcd_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(gcd_pkg::ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint lat_cosine(longint lat);
    longint m, c, s;
    bit flip;
    m = (lat < 0) ? -lat : lat;
    flip = 1'b0;
    if (m > DEG90) begin
      m = DEG180 - m;
      flip = 1'b1;
    end
    rotate(deg_to_rad(m, 30) * 2, c, s);
    return flip ? -c : c;
  endfunction

  function automatic longint half_sine_sq(longint d);
    longint m, c, s;
    m = d % DEG360;
    if (m < 0) m += DEG360;
    if (m >= DEG180) m -= DEG360;
    rotate(deg_to_rad(m, 31) * 2, c, s);
    return q30_mul(s, s);
  endfunction

  function automatic logic [24:0] distance_of(coord_pair_t p);
    longint la, oa, lb, ob, a, z, d;
    la = p.lat_a;
    oa = p.lon_a;
    lb = p.lat_b;
    ob = p.lon_b;
    a = half_sine_sq(lb - la) +
        q30_mul(q30_mul(lat_cosine(la), lat_cosine(lb)), half_sine_sq(ob - oa));
    if (a < 0) a = 0;
    if (a > ONE_L) a = ONE_L;
    z = vector_angle(root_q30(a), root_q30(ONE_L - a));
    if (z < 0) z = 0;
    d = (64'd12742000 * z + (ONE_L >>> 1)) >>> 30;
    if (d > DMAX_L) d = DMAX_L;
    return d[24:0];
  endfunction

  class distance_board;
    logic [24:0] pending_q[$];
    int fails;

    function void note_pair(coord_pair_t p);
      pending_q.push_back(distance_of(p));
    endfunction

    function void check_distance(logic [31:0] data);
      logic [24:0] want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected distance %0d", $time, data[24:0]);
        fails++;
        return;
      end
      want = pending_q.pop_front();
      if (data[24:0] !== want) begin
        $display("%0t: distance_m expected %0d actual %0d", $time, want, data[24:0]);
        fails++;
      end
    endfunction
  endclass

  distance_board board = new();

  // Accept results; the receiver stalls at random per the current phase.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_distance(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Present one pair, holding it until accepted; idle beforehand at random.
  task automatic send_pair(coord_pair_t p);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, p};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pair(p);
  endtask

  function automatic logic signed [27:0] rand_lat(bit raw);
    if (raw) return $signed(28'($urandom));
    return $signed(28'(longint'($urandom_range(180000000)) - DEG90));
  endfunction

  function automatic logic signed [28:0] rand_lon(bit raw);
    if (raw) return $signed(29'($urandom));
    return $signed(29'(longint'($urandom_range(360000000)) - DEG180));
  endfunction

  task automatic send_fields(longint la, longint oa, longint lb, longint ob);
    coord_pair_t p;
    p.lat_a = 28'(la);
    p.lon_a = 29'(oa);
    p.lat_b = 28'(lb);
    p.lon_b = 29'(ob);
    send_pair(p);
  endtask

  task automatic random_phase(int count);
    coord_pair_t p;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(9);
      p.lat_a = rand_lat(pick == 0);
      p.lon_a = rand_lon(pick == 0);
      if (pick inside {[1:3]}) begin
        // nearby point: short distances exercise small haversine terms
        p.lat_b = p.lat_a + $signed(28'($urandom_range(2000000) - 1000000));
        p.lon_b = p.lon_a + $signed(29'($urandom_range(2000000) - 1000000));
      end else if (pick == 4) begin
        // near antipode: drives the saturation region
        p.lat_b = -p.lat_a;
        p.lon_b = p.lon_a + $signed(29'(DEG180 + $urandom_range(20000) - 10000));
      end else begin
        p.lat_b = rand_lat(pick == 0);
        p.lon_b = rand_lon(pick == 0);
      end
      send_pair(p);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identical points, poles, antipodes, dateline, wrap, raw extremes.
    src_gap_pct = 13;
    snk_stall_pct = 63;
    send_fields(0, 0, 0, 0);
    send_fields(90000000, 0, -90000000, 0);
    send_fields(0, 0, 0, 180000000);
    send_fields(0, -180000000, 0, 180000000);
    send_fields(0, 179999999, 0, -179999999);
    send_fields(-90000000, -180000000, 90000000, 180000000);
    send_fields(45000000, 10000000, -45000000, -170000000);
    send_fields(1, 0, 0, 1);
    send_fields(0, 0, 1, 0);
    send_fields(89999999, 0, 89999999, 180000000);
    send_fields(134217727, 268435455, -134217728, -268435456);
    send_fields(-134217728, -268435456, 134217727, 268435455);
    send_fields(134217727, 0, 134217727, 0);
    send_fields(100000000, 0, 80000000, 0);
    send_fields(0, 90000000, 0, -90000000);
    send_fields(51500000, -120000, 40700000, -74000000);
    send_fields(-33900000, 151200000, 51500000, -120000);
    send_fields(10, 10, 10, 10);
    send_fields(0, 0, 0, 200000000);

    random_phase(360);
    src_gap_pct = 63;
    snk_stall_pct = 13;
    random_phase(360);
    src_gap_pct = 0;
    snk_stall_pct = 0;
    random_phase(380);
    s_axis_tvalid <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    err_cnt = board.fails;
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/gcd_pkg.sv
rtl/gcd_cordic.sv
rtl/gcd_isqrt.sv
rtl/great_circle_distance_core.sv
dv/tb.sv
